FILE: sv/ptc_pkg.sv
// Shared constants and helpers for the pressure/temperature compensation block.
package ptc_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned HalfW    = DataW / 2;
  localparam int unsigned CoeffW   = 16;
  localparam int unsigned RawW     = 20;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned AddrW    = 6;

  localparam logic [DataW-1:0] OffsetFine = 64'd128000;
  localparam logic [DataW-1:0] FullScale  = 64'd1048576;
  localparam logic [DataW-1:0] DivScale   = 64'd3125;
  localparam logic [DataW-1:0] DenBias    = 64'h0000_8000_0000_0000;
  localparam logic [31:0]      TempRound  = 32'd128;

  typedef enum logic [2:0] {
    REG_S0_TEMP  = 3'd0,
    REG_S0_PA    = 3'd1,
    REG_S0_PB    = 3'd2,
    REG_S0_NINE  = 3'd3,
    REG_S1_TEMP  = 3'd4,
    REG_S1_PA    = 3'd5,
    REG_S1_PB    = 3'd6,
    REG_S1_NINE  = 3'd7
  } reg_idx_e;

  function automatic logic [DataW-1:0] sext16(logic [CoeffW-1:0] v);
    return {{(DataW-CoeffW){v[CoeffW-1]}}, v};
  endfunction

endpackage

FILE: sv/ptc_mul.sv
// Iterative 64x64 multiplier (low 64 bits) built from one 32x32 multiplier.
module ptc_mul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ptc_pkg::DataW-1:0] a_i,
  input  logic [ptc_pkg::DataW-1:0] b_i,
  output logic                      done_o,
  output logic [ptc_pkg::DataW-1:0] prod_o
);
  import ptc_pkg::*;

  logic [DataW-1:0] a_q, b_q, acc_q, acc_d, prod_q;
  logic [1:0]       cnt_q;
  logic             busy_q, done_q;
  logic [HalfW-1:0] op_a, op_b;

  always_comb begin
    unique case (cnt_q)
      2'd0:    begin op_a = a_q[HalfW-1:0];     op_b = b_q[HalfW-1:0];     end
      2'd1:    begin op_a = a_q[HalfW-1:0];     op_b = b_q[DataW-1:HalfW]; end
      default: begin op_a = a_q[DataW-1:HalfW]; op_b = b_q[HalfW-1:0];     end
    endcase
    unique case (cnt_q)
      2'd0:    acc_d = acc_q;
      2'd1:    acc_d = prod_q;
      default: acc_d = acc_q + {prod_q[HalfW-1:0], {HalfW{1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      prod_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q    <= a_i;
        b_q    <= b_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        prod_q <= DataW'(op_a) * DataW'(op_b);
        acc_q  <= acc_d;
        cnt_q  <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: sv/ptc_div.sv
// Iterative signed 64-bit divider, truncating, one quotient bit per cycle.
module ptc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ptc_pkg::DataW-1:0] num_i,
  input  logic [ptc_pkg::DataW-1:0] den_i,
  output logic                      done_o,
  output logic [ptc_pkg::DataW-1:0] quo_o
);
  import ptc_pkg::*;

  logic [DataW-1:0] quo_q, den_q;
  logic [DataW:0]   rem_q, rem_sh, rem_sub;
  logic [6:0]       cnt_q;
  logic             busy_q, done_q, neg_q;

  assign rem_sh  = {rem_q[DataW-1:0], quo_q[DataW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q  <= num_i[DataW-1] ? (DataW'(0) - num_i) : num_i;
        den_q  <= den_i[DataW-1] ? (DataW'(0) - den_i) : den_i;
        neg_q  <= num_i[DataW-1] ^ den_i[DataW-1];
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (cnt_q == 7'(DataW)) begin
          if (neg_q) begin
            quo_q <= DataW'(0) - quo_q;
          end
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          if (!rem_sub[DataW]) begin
            rem_q <= rem_sub;
            quo_q <= {quo_q[DataW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[DataW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 7'd1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: sv/pressure_temperature_compensation.sv
// Top level: register file, sequencer and shared multiplier/divider.
// A temperature transaction makes three passes through the shared multiplier; a pressure
// transaction makes ten multiplier passes plus one pass through the bit-serial divider,
// fewer when the divisor is zero.
// The input is taken only while the sequencer is idle; one result register holds the
// last result until taken, and a finished transaction waits there if it is still full.
// Coefficients sit at byte address 8*i on the 64-bit register port.
module pressure_temperature_compensation (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptc_pkg::AddrW-1:0]   paddr,
  input  logic [ptc_pkg::DataW-1:0]   pwdata,
  output logic [ptc_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic                        sensor_select_i,
  input  logic [ptc_pkg::RawW-1:0]    raw_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        result_kind_o,
  output logic signed [31:0]          temperature_centi_o,
  output logic [31:0]                 pressure_q24_8_o,
  output logic                        divide_by_zero_o
);
  import ptc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_T1, ST_T2, ST_T3,
    ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
    ST_PDIV, ST_P8, ST_P9, ST_P10, ST_PFIN, ST_OUT
  } state_e;

  state_e state_q;

  logic [47:0]       tc_q [2];
  logic [DataW-1:0]  pa_q [2];
  logic [DataW-1:0]  pb_q [2];
  logic [CoeffW-1:0] p9_q [2];

  logic             kind_q, sel_q, go_q, zero_q, out_valid_q;
  logic [RawW-1:0]  raw_q;
  logic [31:0]      ft_q, ft_d, temp_c;
  logic [DataW-1:0] x_q, xx_q, acc_a_q, acc_b_q, q_q;
  logic             out_kind_q, out_zero_q;
  logic [31:0]      out_temp_q, out_press_q;

  logic             wr_en, in_acc, out_free;
  reg_idx_e         widx;
  logic [DataW-1:0] mul_a, mul_b, mul_p, div_q, den_c, pr64;
  logic             mul_start, mul_done, div_start, div_done;
  logic [15:0]      c1, c2, c3;
  logic [DataW-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign widx    = reg_idx_e'(paddr[AddrW-1:3]);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (widx)
      REG_S0_TEMP: prdata = {16'b0, tc_q[0]};
      REG_S0_PA:   prdata = pa_q[0];
      REG_S0_PB:   prdata = pb_q[0];
      REG_S0_NINE: prdata = {48'b0, p9_q[0]};
      REG_S1_TEMP: prdata = {16'b0, tc_q[1]};
      REG_S1_PA:   prdata = pa_q[1];
      REG_S1_PB:   prdata = pb_q[1];
      default:     prdata = {48'b0, p9_q[1]};
    endcase
  end

  assign c1 = tc_q[sel_q][15:0];
  assign c2 = tc_q[sel_q][31:16];
  assign c3 = tc_q[sel_q][47:32];
  assign p1 = {48'b0, pa_q[sel_q][15:0]};
  assign p2 = sext16(pa_q[sel_q][31:16]);
  assign p3 = sext16(pa_q[sel_q][47:32]);
  assign p4 = sext16(pa_q[sel_q][63:48]);
  assign p5 = sext16(pb_q[sel_q][15:0]);
  assign p6 = sext16(pb_q[sel_q][31:16]);
  assign p7 = sext16(pb_q[sel_q][47:32]);
  assign p8 = sext16(pb_q[sel_q][63:48]);
  assign p9 = sext16(p9_q[sel_q]);

  assign pr64  = FullScale - {{(DataW-RawW){1'b0}}, raw_q};
  assign den_c = DataW'($signed(mul_p) >>> 33);
  assign ft_d  = acc_a_q[31:0] + 32'($signed(mul_p[31:0]) >>> 14);
  assign temp_c = 32'($signed((ft_d << 2) + ft_d + TempRound) >>> 8);

  always_comb begin
    mul_a = x_q;
    mul_b = x_q;
    unique case (state_q)
      ST_T1: begin
        mul_a = {32'b0, ({15'b0, raw_q[19:3]} - {15'b0, c1, 1'b0})};
        mul_b = sext16(c2);
      end
      ST_T2: begin
        mul_a = {32'b0, ({16'b0, raw_q[19:4]} - {16'b0, c1})};
        mul_b = mul_a;
      end
      ST_T3:  begin mul_a = acc_b_q;                         mul_b = sext16(c3); end
      ST_P2:  begin mul_a = xx_q;                            mul_b = p6; end
      ST_P3:  begin mul_a = x_q;                             mul_b = p5; end
      ST_P4:  begin mul_a = xx_q;                            mul_b = p3; end
      ST_P5:  begin mul_a = x_q;                             mul_b = p2; end
      ST_P6:  begin mul_a = acc_b_q;                         mul_b = p1; end
      ST_P7:  begin mul_a = (pr64 << 31) - acc_a_q;          mul_b = DivScale; end
      ST_P8:  begin mul_a = p9;                              mul_b = xx_q; end
      ST_P9:  begin mul_a = acc_a_q;                         mul_b = xx_q; end
      ST_P10: begin mul_a = p8;                              mul_b = q_q; end
      default: begin mul_a = x_q;                            mul_b = x_q; end
    endcase
  end

  assign mul_start = go_q && (state_q != ST_IDLE) && (state_q != ST_PDIV)
                     && (state_q != ST_PFIN) && (state_q != ST_OUT);
  assign div_start = go_q && (state_q == ST_PDIV);

  ptc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  ptc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_a_q),
    .den_i   (acc_b_q),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
      ft_q        <= '0;
      for (int i = 0; i < 2; i++) begin
        tc_q[i] <= '0;
        pa_q[i] <= '0;
        pb_q[i] <= '0;
        p9_q[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        unique case (widx)
          REG_S0_TEMP: tc_q[0] <= pwdata[47:0];
          REG_S0_PA:   pa_q[0] <= pwdata;
          REG_S0_PB:   pb_q[0] <= pwdata;
          REG_S0_NINE: p9_q[0] <= pwdata[15:0];
          REG_S1_TEMP: tc_q[1] <= pwdata[47:0];
          REG_S1_PA:   pa_q[1] <= pwdata;
          REG_S1_PB:   pb_q[1] <= pwdata;
          default:     p9_q[1] <= pwdata[15:0];
        endcase
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (mul_start || div_start) begin
        go_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            kind_q  <= operation_i;
            sel_q   <= sensor_select_i;
            raw_q   <= raw_sample_i;
            zero_q  <= 1'b0;
            x_q     <= {{32{ft_q[31]}}, ft_q} - OffsetFine;
            go_q    <= 1'b1;
            state_q <= operation_i ? ST_P1 : ST_T1;
          end
        end
        ST_T1: if (mul_done) begin
          acc_a_q <= {32'b0, 32'($signed(mul_p[31:0]) >>> 11)};
          go_q <= 1'b1; state_q <= ST_T2;
        end
        ST_T2: if (mul_done) begin
          acc_b_q <= {32'b0, 32'($signed(mul_p[31:0]) >>> 12)};
          go_q <= 1'b1; state_q <= ST_T3;
        end
        ST_T3: if (mul_done) begin
          ft_q    <= ft_d;
          acc_a_q <= {32'b0, temp_c};
          state_q <= ST_OUT;
        end
        ST_P1: if (mul_done) begin
          xx_q <= mul_p; go_q <= 1'b1; state_q <= ST_P2;
        end
        ST_P2: if (mul_done) begin
          acc_a_q <= mul_p; go_q <= 1'b1; state_q <= ST_P3;
        end
        ST_P3: if (mul_done) begin
          acc_a_q <= acc_a_q + (mul_p << 17) + (p4 << 35);
          go_q <= 1'b1; state_q <= ST_P4;
        end
        ST_P4: if (mul_done) begin
          acc_b_q <= DataW'($signed(mul_p) >>> 8);
          go_q <= 1'b1; state_q <= ST_P5;
        end
        ST_P5: if (mul_done) begin
          acc_b_q <= acc_b_q + (mul_p << 12) + DenBias;
          go_q <= 1'b1; state_q <= ST_P6;
        end
        ST_P6: if (mul_done) begin
          acc_b_q <= den_c;
          if (den_c == '0) begin
            zero_q  <= 1'b1;
            acc_a_q <= '0;
            state_q <= ST_OUT;
          end else begin
            go_q <= 1'b1; state_q <= ST_P7;
          end
        end
        ST_P7: if (mul_done) begin
          acc_a_q <= mul_p; go_q <= 1'b1; state_q <= ST_PDIV;
        end
        ST_PDIV: if (div_done) begin
          q_q  <= div_q;
          xx_q <= DataW'($signed(div_q) >>> 13);
          go_q <= 1'b1; state_q <= ST_P8;
        end
        ST_P8: if (mul_done) begin
          acc_a_q <= mul_p; go_q <= 1'b1; state_q <= ST_P9;
        end
        ST_P9: if (mul_done) begin
          acc_a_q <= DataW'($signed(mul_p) >>> 25);
          go_q <= 1'b1; state_q <= ST_P10;
        end
        ST_P10: if (mul_done) begin
          acc_a_q <= q_q + acc_a_q + DataW'($signed(mul_p) >>> 19);
          state_q <= ST_PFIN;
        end
        ST_PFIN: begin
          acc_a_q <= DataW'($signed(acc_a_q) >>> 8) + (p7 << 4);
          state_q <= ST_OUT;
        end
        ST_OUT: if (out_free) begin
          out_valid_q <= 1'b1;
          out_kind_q  <= kind_q;
          out_temp_q  <= kind_q ? 32'b0 : acc_a_q[31:0];
          out_press_q <= kind_q ? acc_a_q[31:0] : 32'b0;
          out_zero_q  <= kind_q && zero_q;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = out_kind_q;
  assign temperature_centi_o = out_temp_q;
  assign pressure_q24_8_o    = out_press_q;
  assign divide_by_zero_o    = out_zero_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while sequencer busy");

  a_zero_only_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> result_kind_o && pressure_q24_8_o == 32'b0)
    else $error("divide flag on a non-pressure result");

  a_temp_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |-> pressure_q24_8_o == 32'b0)
    else $error("pressure field set on temperature result");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

endmodule
